// ===== design/rmst_pkg.sv =====
// Shared types, constants and handshake structs for the range-maximum segment tree.
package rmst_pkg;

  localparam int unsigned IDX_W          = 11;
  localparam int unsigned VAL_W          = 31;
  localparam int unsigned LEAVES_DEFAULT = 1024;
  localparam logic [IDX_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
    logic [VAL_W-1:0] new_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] max_value;
    logic             range_error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic w_leaf;
    logic w_up;
    logic q_chk;
    logic q_b;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_err;
    logic in_query;
    logic at_root;
    logic q_more;
  } sts_t;

endpackage

// ===== design/rmst_ctrl.sv =====
// Sequencer for clearing, point writes, range queries and the result register.
module rmst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  rmst_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output rmst_pkg::cmd_t cmd_o
);
  import rmst_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WLEAF = 3'd2;
  localparam logic [2:0] S_WUP   = 3'd3;
  localparam logic [2:0] S_QCHK  = 3'd4;
  localparam logic [2:0] S_QB    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_err) begin
            state_d = S_DONE;
          end else if (sts_i.in_query) begin
            state_d = S_QCHK;
          end else begin
            state_d = S_WLEAF;
          end
        end
      end
      S_WLEAF: begin
        cmd_o.w_leaf = 1'b1;
        state_d      = S_WUP;
      end
      S_WUP: begin
        cmd_o.w_up = 1'b1;
        if (sts_i.at_root) begin
          state_d = S_IDLE;
        end
      end
      S_QCHK: begin
        cmd_o.q_chk = 1'b1;
        state_d     = sts_i.q_more ? S_QB : S_DONE;
      end
      S_QB: begin
        cmd_o.q_b = 1'b1;
        state_d   = S_QCHK;
      end
      S_DONE: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/rmst_dp.sv =====
// Tree memory, index walkers, maximum accumulator, count register and result register.
module rmst_dp #(
  parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rmst_pkg::IDX_W-1:0] cfg_data_i,
  input  rmst_pkg::in_t              in_data_i,
  input  rmst_pkg::cmd_t             cmd_i,
  output rmst_pkg::sts_t             sts_o,
  output rmst_pkg::out_t             out_data_o
);
  import rmst_pkg::*;

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned NW1   = $clog2(NODES + 1);
  localparam int unsigned LW    = $clog2(LEAVES + 1);
  localparam int unsigned CW    = (IDX_W > LW) ? IDX_W : LW;

  logic [VAL_W-1:0] mem [NODES];
  logic [VAL_W-1:0] rd_q;

  logic             we, re;
  logic [NW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic [IDX_W-1:0] count_q;
  logic [NW-1:0]    clr_q;
  logic             pend_q, pend_d;
  logic [NW1-1:0]   a_q, a_d, b_q, b_d;
  logic [VAL_W-1:0] best_q, best_d, val_q, val_d;
  logic             err_q, err_d;
  out_t             out_q;

  logic [CW-1:0]    cnt, first_w, last_w;
  logic [NW1-1:0]   parent, b_dec;
  logic [VAL_W-1:0] best_next, up_max;

  // count in use saturates at LEAVES
  assign first_w = CW'(in_data_i.first_index);
  assign last_w  = CW'(in_data_i.last_index);
  assign cnt     = (CW'(count_q) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(count_q);

  always_comb begin
    sts_o.clr_last = (clr_q == NW'(NODES - 1));
    sts_o.in_query = (in_data_i.operation == OP_QUERY);
    if (in_data_i.operation == OP_QUERY) begin
      sts_o.in_err = (first_w == '0) || (last_w > cnt) || (first_w > last_w);
    end else begin
      sts_o.in_err = (first_w == '0) || (first_w > cnt);
    end
    sts_o.at_root = ((a_q >> 1) == NW1'(1));
    sts_o.q_more  = (a_q < b_q);
  end

  assign parent    = a_q >> 1;
  assign b_dec     = b_q[0] ? (b_q - NW1'(1)) : b_q;
  assign best_next = (pend_q && (rd_q > best_q)) ? rd_q : best_q;
  assign up_max    = (rd_q > best_q) ? rd_q : best_q;

  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    waddr  = clr_q;
    raddr  = a_q[NW-1:0];
    wdata  = '0;
    a_d    = a_q;
    b_d    = b_q;
    best_d = best_q;
    val_d  = val_q;
    err_d  = err_q;
    pend_d = pend_q;
    if (cmd_i.clr_en) begin
      we = 1'b1;
    end
    if (cmd_i.accept) begin
      a_d    = NW1'(LEAVES) + NW1'(in_data_i.first_index) - NW1'(1);
      b_d    = NW1'(LEAVES) + NW1'(in_data_i.last_index);
      val_d  = in_data_i.new_value;
      best_d = '0;
      err_d  = sts_o.in_err;
      pend_d = 1'b0;
    end
    if (cmd_i.w_leaf) begin
      we     = 1'b1;
      waddr  = a_q[NW-1:0];
      wdata  = val_q;
      re     = 1'b1;
      raddr  = a_q[NW-1:0] ^ NW'(1);
      best_d = val_q;
    end
    if (cmd_i.w_up) begin
      we     = 1'b1;
      waddr  = parent[NW-1:0];
      wdata  = up_max;
      re     = 1'b1;
      raddr  = parent[NW-1:0] ^ NW'(1);
      best_d = up_max;
      a_d    = parent;
    end
    if (cmd_i.q_chk) begin
      best_d = best_next;
      if (sts_o.q_more && a_q[0]) begin
        re     = 1'b1;
        raddr  = a_q[NW-1:0];
        a_d    = a_q + NW1'(1);
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (cmd_i.q_b) begin
      best_d = best_next;
      re     = b_q[0];
      raddr  = b_dec[NW-1:0];
      pend_d = b_q[0];
      b_d    = b_dec >> 1;
      a_d    = a_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + NW'(1);
      end
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    best_q <= best_d;
    val_q  <= val_d;
    err_q  <= err_d;
    if (cmd_i.out_load) begin
      out_q.max_value   <= best_q;
      out_q.range_error <= err_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== design/range_max_segment_tree.sv =====
// Range-maximum segment tree with point writes: top level.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): one transfer per item. A write stores
// new_value at position first_index and gives no result; a query gives one result with
// the maximum over first_index..last_index. A bad index or reversed range gives one
// result with range_error set and max_value zero, and leaves the tree untouched.
// Output channel (out_valid_o/out_ready_i, out_data_o) is a register; the block takes
// the next item while a result waits, and holds a finished result until that register
// is free. Config channel (cfg_valid_i/cfg_ready_o) writes element_count, always ready.
// A write steps from the leaf up to the root, one tree level a cycle through the
// single-write, single-read tree memory. A query alternates a check step and a B step per
// level, since each level may need two reads on the one read port. A result is loaded
// into the output register from the done state once that register is free.
// Reset: a clearing pass zeroes the 2*LEAVES tree nodes, one per cycle, with in_ready_o
// low; element_count resets to 1024.
module range_max_segment_tree #(
  parameter int unsigned LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rmst_pkg::IDX_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rmst_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rmst_pkg::out_t             out_data_o
);
  import rmst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rmst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  rmst_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !in_ready_o)
    else $error("input ready during clearing pass");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_en, cmd.accept, cmd.w_leaf, cmd.w_up, cmd.q_chk, cmd.q_b,
              cmd.out_load}))
    else $error("more than one datapath command");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_WRITE && !sts.in_err)
      |=> !$rose(out_valid_o))
    else $error("valid write produced a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.range_error) |-> (out_data_o.max_value == '0))
    else $error("flagged result with non-zero maximum");
`endif

endmodule
